@@ hw/rtl/b64u_pkg.sv @@
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, status codes and the character decode table for the Base64
// stream decoder.
// ----------------------------------------------------------------------------
package b64u_pkg;

  localparam int unsigned CharCountW = 23;
  localparam logic [CharCountW-1:0] MaxCharsReset = 23'd4194304;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StEmpty   = 3'd1;
  localparam logic [2:0] StTooLong = 3'd2;
  localparam logic [2:0] StBadPad  = 3'd3;
  localparam logic [2:0] StBadChar = 3'd4;
  localparam logic [2:0] StBadLen  = 3'd5;

  localparam logic [15:0] ChPad = 16'h003D;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_char;
    logic        end_of_payload;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       final_res;
    logic [2:0] status;
  } out_item_t;

  // bit 6 flags a character of either alphabet, bits 5:0 give its value
  function automatic logic [6:0] sextet_f(logic [15:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 16'h0041 && c <= 16'h005A) begin
      r = {1'b1, 6'(c - 16'h0041)};
    end else if (c >= 16'h0061 && c <= 16'h007A) begin
      r = {1'b1, 6'(c - 16'h0047)};
    end else if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b1, 6'(c + 16'h0004)};
    end else if (c == 16'h002D || c == 16'h002B) begin
      r = {1'b1, 6'd62};
    end else if (c == 16'h005F || c == 16'h002F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/base64url_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// base64url_stream_decoder_top
// Base64 decoder (URL and standard alphabets), one character per item.
//
// Input channel (in_valid_i/in_ready_o/in_item_i): one UTF-16 code unit per
// item, with has_char and end_of_payload flags. Output channel
// (out_valid_o/out_ready_i/out_item_o): a decoded byte, a final status, or
// both in one item. Items without a byte and without end give no output.
// Path: an item is registered at the input, then decoded into the result
// register, which drives out_valid_o and out_item_o.
// Throughput: one item per cycle unless stalled; the decode is a single
// shift-and-or on a 6-bit pending buffer between the two registers.
// Stall: while a result waits, one more item is held in the input register;
// after that in_ready_o drops until the receiver takes the result.
// Reset: all payload state clears and max_chars returns to 4194304.
// cfg_we_i writes max_chars from cfg_wdata_i; write only when idle.
// ----------------------------------------------------------------------------
module base64url_stream_decoder_top import b64u_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CharCountW-1:0] cfg_wdata_i
);

  logic [CharCountW-1:0] max_chars_q;
  logic                  take;
  logic                  item_valid;
  in_item_t              item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= MaxCharsReset;
    end else if (cfg_we_i) begin
      max_chars_q <= cfg_wdata_i;
    end
  end

  b64u_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  b64u_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .max_chars_i  (max_chars_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

@@ hw/rtl/b64u_in_reg.sv @@
// ----------------------------------------------------------------------------
// b64u_in_reg
// Input register: holds one accepted item until the core takes it.
// ----------------------------------------------------------------------------
module b64u_in_reg import b64u_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     take_i,
  output logic     item_valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

@@ hw/rtl/b64u_core.sv @@
// ----------------------------------------------------------------------------
// b64u_core
// Decode state, per-character update and the result register.
// ----------------------------------------------------------------------------
module b64u_core import b64u_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  in_item_t              item_i,
  output logic                  take_o,
  input  logic [CharCountW-1:0] max_chars_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  logic [5:0]            buf_q, buf_d;
  logic [2:0]            cnt_q, cnt_d;
  logic                  pad_q, pad_d;
  logic [2:0]            err_q, err_d;
  logic [CharCountW-1:0] chars_q, chars_d;
  logic                  out_valid_q;
  out_item_t             out_item_q, out_item_d;
  logic                  emit;

  assign take_o      = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    logic [6:0]  sx;
    logic [11:0] acc;
    logic        full;
    logic [7:0]  byte_v;
    logic [5:0]  buf_n;
    logic [2:0]  cnt_n;
    logic [2:0]  st;

    buf_d   = buf_q;
    cnt_d   = cnt_q;
    pad_d   = pad_q;
    err_d   = err_q;
    chars_d = chars_q;
    out_item_d = '0;
    emit    = 1'b0;
    st      = StOk;

    sx  = sextet_f(item_i.code_unit);
    acc = {buf_q, sx[5:0]};
    full   = 1'b1;
    byte_v = '0;
    buf_n  = '0;
    cnt_n  = '0;
    case (cnt_q)
      3'd2: begin
        byte_v = acc[7:0];
        cnt_n  = 3'd0;
      end
      3'd4: begin
        byte_v = acc[9:2];
        buf_n  = {4'd0, acc[1:0]};
        cnt_n  = 3'd2;
      end
      3'd6: begin
        byte_v = acc[11:4];
        buf_n  = {2'd0, acc[3:0]};
        cnt_n  = 3'd4;
      end
      default: begin
        full  = 1'b0;
        buf_n = acc[5:0];
        cnt_n = 3'd6;
      end
    endcase

    if (item_i.has_char) begin
      if (chars_q != '1) begin
        chars_d = chars_q + 1'b1;
      end
      if (err_q == StOk) begin
        if (item_i.code_unit == ChPad) begin
          pad_d = 1'b1;
        end else if (pad_q) begin
          err_d = StBadPad;
        end else if (!sx[6]) begin
          err_d = StBadChar;
        end else begin
          buf_d = buf_n;
          cnt_d = cnt_n;
          if (full && chars_d <= max_chars_i) begin
            out_item_d.byte_valid = 1'b1;
            out_item_d.out_byte   = byte_v;
          end
        end
      end
    end

    if (item_i.end_of_payload) begin
      if (chars_d == '0) begin
        st = StEmpty;
      end else if (chars_d > max_chars_i) begin
        st = StTooLong;
      end else if (err_d != StOk) begin
        st = err_d;
      end else if (cnt_d == 3'd6 || (cnt_d != 3'd0 && buf_d != 6'd0)) begin
        st = StBadLen;
      end
      out_item_d.final_res = 1'b1;
      out_item_d.status    = st;
      buf_d   = '0;
      cnt_d   = '0;
      pad_d   = 1'b0;
      err_d   = StOk;
      chars_d = '0;
    end

    emit = out_item_d.byte_valid || item_i.end_of_payload;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      cnt_q       <= '0;
      pad_q       <= 1'b0;
      err_q       <= StOk;
      chars_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        buf_q       <= buf_d;
        cnt_q       <= cnt_d;
        pad_q       <= pad_d;
        err_q       <= err_d;
        chars_q     <= chars_d;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

@@ hw/rtl/b64u_checker.sv @@
// ----------------------------------------------------------------------------
// b64u_checker
// Port-level checks on the decoder output, bound to the top level.
// ----------------------------------------------------------------------------
module b64u_checker import b64u_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item dropped or changed while stalled");

  a_out_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.byte_valid || out_item_o.final_res)
    else $error("output item with neither byte nor final flag");

  a_status_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.final_res |-> out_item_o.status == StOk)
    else $error("status set on a non-final item");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.byte_valid |-> out_item_o.out_byte == 8'd0)
    else $error("byte field set without byte_valid");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status <= StBadLen)
    else $error("status code out of range");

endmodule

bind base64url_stream_decoder_top b64u_checker u_b64u_checker (.*);
